// ===== rtl/sfbs_pkg.sv =====
// Shared types and constants of the sample frame byte stuffer.
package sfbs_pkg;

  localparam logic [7:0] BYTE_START = 8'hFE;
  localparam logic [7:0] BYTE_ESC   = 8'hFD;
  localparam logic [7:0] BYTE_END   = 8'hFC;
  localparam logic [7:0] ESC_FLIP   = 8'h20;

  localparam int unsigned VALUE_BYTES = 4;
  localparam int unsigned IDX_W       = $clog2(VALUE_BYTES);
  localparam int unsigned CFG_W       = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [31:0] value;
    logic        first_value;
    logic        last_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_item_t;

  // Classified item as it waits between the front and back parts.
  typedef struct packed {
    logic [31:0]            value;
    logic [VALUE_BYTES-1:0] esc;
    logic [IDX_W-1:0]       last_idx;
    logic                   first_value;
    logic                   last_value;
  } desc_t;

  typedef enum logic [1:0] {
    ST_HEAD,
    ST_DATA,
    ST_ESC2,
    ST_TAIL
  } back_state_t;

endpackage

// ===== rtl/sample_frame_byte_stuffer.sv =====
// Top level of the sample frame byte stuffer.
//
// The block turns sample values into a framed, byte-stuffed byte stream.
// Input side: an item (value and frame flags) is taken at a rising edge with
// push high and full low. The low bytes_per_value bytes of the value go out
// least significant first; a start byte 0xFE comes first when first_value is
// set and an end byte 0xFC comes last when last_value is set. A data byte of
// 0xFC, 0xFD or 0xFE is sent as 0xFD followed by the byte XOR 0x20.
// Output side: while empty is low, out_item holds the oldest byte; it is
// taken at an edge with pop high. run_end marks the last byte of an item.
// Configuration: cfg_we writes cfg_wdata into bytes_per_value (0 acts as 1,
// 5 to 7 as 4); reset loads 2. Write it only while the block is idle.
// Timing: an item is first registered in the queue, and each of its bytes then
// goes into the output register. The back end emits one byte per cycle while
// the receiver keeps up, and an item yields 1 to 10 bytes; the byte-per-cycle
// output register is what sets the rate. A two-entry queue lets the front
// take new items while the back end is busy.
// When the receiver stalls, the output byte holds, the back end stops, and
// full rises once the queue is full. Reset empties the queue and the output.
module sample_frame_byte_stuffer
  import sfbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  desc_t front_desc;
  desc_t head_desc;
  logic  q_empty;
  logic  q_pop;
  logic  q_full;

  // The front classifies each incoming item: clamped byte count and escapes.
  sfbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .desc      (front_desc)
  );

  assign full = q_full;

  // Classified items wait here until the back end gets to them.
  sfbs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !q_full),
    .wr_data (front_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head_desc),
    .empty   (q_empty)
  );

  // The back end sequences start, data, escape and end bytes of the head item.
  sfbs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .desc     (head_desc),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== rtl/sfbs_front.sv =====
// Front part: holds the byte count register and classifies incoming items.
module sfbs_front
  import sfbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  in_item_t         in_item,
  output desc_t            desc
);

  logic [CFG_W-1:0] bpv_r;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpv_r <= CFG_RESET;
    end else if (cfg_we) begin
      bpv_r <= cfg_wdata;
    end
  end

  // Zero counts as one byte, anything above four as four.
  always_comb begin
    if (bpv_r == '0) begin
      last_idx = '0;
    end else if (bpv_r > CFG_W'(VALUE_BYTES)) begin
      last_idx = IDX_W'(VALUE_BYTES - 1);
    end else begin
      last_idx = IDX_W'(bpv_r - 3'd1);
    end
  end

  always_comb begin
    desc.value       = in_item.value;
    desc.first_value = in_item.first_value;
    desc.last_value  = in_item.last_value;
    desc.last_idx    = last_idx;
    b                = '0;
    for (int k = 0; k < VALUE_BYTES; k++) begin
      b = in_item.value[8*k +: 8];
      desc.esc[k] = (b == BYTE_END) || (b == BYTE_ESC) || (b == BYTE_START);
    end
  end

endmodule

// ===== rtl/sfbs_queue.sv =====
// Short register queue of classified items between the front and back parts.
module sfbs_queue
  import sfbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  empty
);

  desc_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/sfbs_back.sv =====
// Back part: walks one queued item byte by byte into the output register.
module sfbs_back
  import sfbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  desc_t     desc,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  back_state_t      state_r, state_nxt, cur;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             emit;
  logic             done;
  logic [7:0]       data_b;
  logic             last_byte;

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;
  assign emit     = !q_empty && (!out_valid_r || pop);
  assign q_pop    = emit && done;

  assign data_b    = desc.value[8*idx_r +: 8];
  assign last_byte = (idx_r == desc.last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HEAD;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    // Without a start flag the head step is the first data byte.
    cur = (state_r == ST_HEAD && !desc.first_value) ? ST_DATA : state_r;
    state_nxt             = state_r;
    idx_nxt               = idx_r;
    done                  = 1'b0;
    out_item_nxt.out_byte = data_b;
    out_item_nxt.run_end  = 1'b0;

    unique case (cur)
      ST_HEAD: begin
        out_item_nxt.out_byte = BYTE_START;
        state_nxt             = ST_DATA;
      end
      ST_DATA, ST_ESC2: begin
        if (cur == ST_DATA && desc.esc[idx_r]) begin
          out_item_nxt.out_byte = BYTE_ESC;
          state_nxt             = ST_ESC2;
        end else begin
          out_item_nxt.out_byte = (cur == ST_ESC2) ? (data_b ^ ESC_FLIP) : data_b;
          if (!last_byte) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_DATA;
          end else if (desc.last_value) begin
            state_nxt = ST_TAIL;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        out_item_nxt.out_byte = BYTE_END;
        done                  = 1'b1;
      end
    endcase

    if (done) begin
      state_nxt            = ST_HEAD;
      idx_nxt              = '0;
      out_item_nxt.run_end = 1'b1;
    end

    if (!emit) begin
      state_nxt    = state_r;
      idx_nxt      = idx_r;
      out_item_nxt = out_item_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sample frame byte stuffer: directed and random samples.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfbs_pkg::*;

  // The scoreboard holds its own copy of the byte count register. For every
  // accepted sample it works out the framed, escaped byte run that the block
  // must produce, and it checks each popped byte against the oldest one.
  class stuffed_byte_board;
    logic [CFG_W-1:0] bytes_per_value;
    out_item_t        pending_bytes[$];
    int               errors;

    function new();
      bytes_per_value = CFG_RESET;
      errors = 0;
    endfunction

    // Expand one sample into its byte run and queue the run.
    function void note_sample(in_item_t s);
      out_item_t  run[$];
      out_item_t  tail;
      logic [7:0] b;
      int         count;
      // A count of zero acts as one, and counts above four act as four.
      if (bytes_per_value == 0) begin
        count = 1;
      end else if (bytes_per_value > VALUE_BYTES) begin
        count = VALUE_BYTES;
      end else begin
        count = int'(bytes_per_value);
      end
      if (s.first_value) begin
        run.push_back({BYTE_START, 1'b0});
      end
      // Least significant byte first; framing bytes in the data get escaped.
      for (int k = 0; k < count; k++) begin
        b = s.value[8*k +: 8];
        if (b == BYTE_END || b == BYTE_ESC || b == BYTE_START) begin
          run.push_back({BYTE_ESC, 1'b0});
          run.push_back({b ^ ESC_FLIP, 1'b0});
        end else begin
          run.push_back({b, 1'b0});
        end
      end
      if (s.last_value) begin
        run.push_back({BYTE_END, 1'b0});
      end
      // The last byte of the run carries the end-of-run mark.
      tail = run.pop_back();
      tail.run_end = 1'b1;
      run.push_back(tail);
      foreach (run[i]) begin
        pending_bytes.push_back(run[i]);
      end
    endfunction

    // Compare one popped byte, field by field, with the oldest expectation.
    function void check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h run_end %0b with nothing pending",
                 $time, got.out_byte, got.run_end);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h actual %02h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $display("%0t: run_end expected %0b actual %0b",
                 $time, want.run_end, got.run_end);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             push;
  logic             full;
  in_item_t         in_item;
  logic             empty;
  logic             pop;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  stuffed_byte_board board;

  // Idle rates, in percent of cycles, for the sender and the receiver.
  int send_idle_pct;
  int recv_idle_pct;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_req;

  // Byte count settings, three per idling phase; both extremes and the
  // saturating codes appear, and every bit of the register toggles.
  localparam logic [CFG_W-1:0] COUNT_PLAN [9] = '{
    3'd4, 3'd0, 3'd2, 3'd7, 3'd1, 3'd3, 3'd2, 3'd5, 3'd6
  };
  localparam int ITEMS_PER_SETTING = 28;
  localparam int LONG_HOLD_CYCLES  = 80;
  localparam int SETTLE_CYCLES     = 20;

  sample_frame_byte_stuffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t sample(logic [31:0] v, logic f, logic l);
    in_item_t s;
    s.value       = v;
    s.first_value = f;
    s.last_value  = l;
    return s;
  endfunction

  // Random sample value. Each byte is often one of the three framing codes so
  // that escapes are frequent; now and then the whole word is uniform random.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int          r;
    if ($urandom_range(4) == 0) begin
      return $urandom;
    end
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(9);
      if (r < 3) begin
        v[8*k +: 8] = BYTE_END + 8'(r);
      end else if (r == 3) begin
        v[8*k +: 8] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      end else begin
        v[8*k +: 8] = 8'($urandom_range(255));
      end
    end
    return v;
  endfunction

  // Offer one sample. Called and returning at a falling edge. The push line
  // is lowered only while the sender idles, so it is never dropped and raised
  // in the same time step between back-to-back samples.
  task automatic send_sample(input in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    board.note_sample(s);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected byte has been popped. Since
  // each sample yields at least one byte, the block is idle at that point.
  task automatic drain();
    push <= 1'b0;
    while (board.outstanding() != 0 || !empty) begin
      @(negedge clk);
    end
  endtask

  // Write the byte count register while the block is idle.
  task automatic write_count(input logic [CFG_W-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.bytes_per_value = v;
    @(negedge clk);
  endtask

  // One random frame of one to six samples, flags set properly; returns the
  // number of samples offered.
  task automatic send_frame(output int n);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_sample(sample(random_value(), i == 0, i == n - 1));
    end
  endtask

  // Receiver: decides pop at each falling edge. A long hold-off, once asked
  // for, is counted down here so that it runs while the sender keeps pushing.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Bytes are taken at rising edges where pop is high and empty is low.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      board.check_byte(out_item);
    end
  end

  // Main stimulus.
  initial begin
    int sent;
    int n;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    board         = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, first with the reset count of two bytes: a one-sample
    // frame of zeros, all ones, escapes of every framing code, and flags out
    // of order (an end without a start and a start without an end).
    send_sample(sample(32'h0000_0000, 1'b1, 1'b1));
    send_sample(sample(32'hFFFF_FFFF, 1'b1, 1'b0));
    send_sample(sample(32'h1234_FDFC, 1'b0, 1'b0));
    send_sample(sample(32'hABCD_00FE, 1'b0, 1'b1));
    send_sample(sample(32'h0000_00FC, 1'b0, 1'b1));
    send_sample(sample(32'h55AA_0000, 1'b1, 1'b0));

    // Four bytes: the longest run has every byte escaped plus both frame marks.
    write_count(3'd4);
    send_sample(sample(32'hFEFD_FCFE, 1'b1, 1'b1));
    send_sample(sample(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_sample(sample(32'h0000_0000, 1'b0, 1'b0));
    send_sample(sample(32'h7F80_FC01, 1'b1, 1'b1));

    // A count of zero behaves as one byte.
    write_count(3'd0);
    send_sample(sample(32'hFFFF_FFFD, 1'b1, 1'b1));
    send_sample(sample(32'h1234_5600, 1'b0, 1'b0));

    // Counts above four saturate at four.
    write_count(3'd7);
    send_sample(sample(32'hFCFC_FCFC, 1'b0, 1'b1));
    write_count(3'd5);
    send_sample(sample(32'h0102_0304, 1'b1, 1'b0));

    write_count(3'd1);
    send_sample(sample(32'h0000_00FE, 1'b0, 1'b0));
    write_count(3'd3);
    send_sample(sample(32'hFDFE_00FC, 1'b1, 1'b1));
    send_sample(sample(32'h8000_0001, 1'b0, 1'b0));

    // Random part in three idling phases: a slow receiver, then a slow
    // sender, then no idling at all. Each phase runs three count settings.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < 3; c++) begin
        write_count(COUNT_PLAN[p*3 + c]);
        // With no idling, the receiver stops for a long stretch while the
        // sender keeps pushing, so the queue fills and full must rise.
        if (p == 2 && c == 0) begin
          hold_req = 1'b1;
        end
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          // Once, the sender pauses mid-run until every byte has come out.
          if (p == 0 && c == 1 && sent >= 10 && sent < 16) begin
            drain();
            sent = 16;
          end
          if ($urandom_range(99) < 85) begin
            send_frame(n);
            sent += n;
          end else begin
            // Noise: a lone sample with random flags, which also yields
            // broken frames with a missing start or end.
            send_sample(sample($urandom, 1'($urandom_range(1)), 1'($urandom_range(1))));
            sent++;
          end
        end
      end
    end

    // Wait for all outstanding bytes, then keep watching the output to catch
    // any stray byte the block might still put out.
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
